[hdl/dsbl_pkg.sv]
// ----------------------------------------------------------------------------
// dsbl_pkg
// Shared widths, codes and types of the split band de-esser.
// ----------------------------------------------------------------------------
`default_nettype none

package dsbl_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int COEF_BITS   = 16;

    // gain is q4.x, so its fraction is four bits shorter than a coefficient
    localparam int GAIN_FRAC = COEF_BITS - 4;

    // high band: |rest - mid| < 2^(S+1), times gain < 2^C, down by GAIN_FRAC
    localparam int HF_W  = SAMPLE_BITS + 6;
    localparam int ENV_W = HF_W - 1;
    localparam int THR_W = SAMPLE_BITS - 1;

    // shared multiply-add unit
    localparam int MAC_AW = HF_W + 1;
    localparam int MAC_BW = (THR_W > COEF_BITS + 1) ? THR_W : COEF_BITS + 1;
    localparam int ACC_W  = MAC_AW + MAC_BW + 2;

    // divider: quotient magnitude stays below the high band magnitude
    localparam int DIV_N = HF_W - 1;
    localparam int DVD_W = DIV_N + THR_W;
    localparam int CNT_W = $clog2(DIV_N + 1);

    // configuration port
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = (THR_W > COEF_BITS) ? THR_W : COEF_BITS;

    localparam logic [THR_W-1:0]     THRESHOLD_RST = THR_W'(23640);
    localparam logic [COEF_BITS-1:0] SPLIT_RST     = COEF_BITS'(25454);
    localparam logic [COEF_BITS-1:0] GAIN_RST      = COEF_BITS'(4096);
    localparam logic [COEF_BITS-1:0] ATTACK_RST    = COEF_BITS'(655);
    localparam logic [COEF_BITS-1:0] RELEASE_RST   = COEF_BITS'(65012);

    localparam logic [COEF_BITS:0] COEF_ONE = (COEF_BITS + 1)'(1) << COEF_BITS;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 3'd0,
        CFG_SPLIT     = 3'd1,
        CFG_GAIN      = 3'd2,
        CFG_ATTACK    = 3'd3,
        CFG_RELEASE   = 3'd4
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LP1A,
        ST_LP1B,
        ST_LP2A,
        ST_LP2B,
        ST_HF,
        ST_ENV,
        ST_ENV_UPD,
        ST_DIV_INIT,
        ST_DIV,
        ST_SUM
    } state_t;

    typedef struct packed {
        logic signed [MAC_AW-1:0] a;
        logic        [MAC_BW-1:0] b;
        logic signed [ACC_W-1:0]  c;
    } mac_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

[hdl/deesser_split_band_limiter.sv]
// ----------------------------------------------------------------------------
// deesser_split_band_limiter
// Split band sibilance limiter: mono mix, two one-pole splits, envelope
// follower and high band gain reduction, on one shared multiply-add unit.
// ----------------------------------------------------------------------------
// usage:
//   s_ channel takes one stereo word (left, right q1.23); m_ channel returns
//   one mono q1.23 word per input word, saturated to the sample range.
//   cfg_we / cfg_index / cfg_wdata write the five settings; write them only
//   while no word is in flight. indexes beyond the list are ignored.
// timing:
//   a word walks through seven multiply-add steps and a final sum step, one
//   per cycle while neither the divider nor a full output register holds it.
//   when the envelope is above the threshold, a restoring divider runs before
//   the sum step: a start step, 29 quotient bits, then the quotient is
//   picked up.
//   s_tready is high only between words, so a new word is taken only after
//   the last one has left the sum step; a finished word sits in the output
//   register, so the next input is taken while it waits.
// reset:
//   aresetn (synchronous, low) restores the default settings and clears
//   both filter states and the envelope.
// stall:
//   if the output register still holds an unaccepted word when the next
//   result is done, the block holds that result inside until the register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module deesser_split_band_limiter (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // configuration
    input  wire logic                              cfg_we,
    input  wire logic [dsbl_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [dsbl_pkg::CFG_W-1:0]        cfg_wdata,
    // input stream
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [2*dsbl_pkg::SAMPLE_BITS-1:0] s_tdata,  // left_in, right_in
    // result stream
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [dsbl_pkg::SAMPLE_BITS-1:0]       m_tdata    // mono_out
);

    localparam int S     = dsbl_pkg::SAMPLE_BITS;
    localparam int C     = dsbl_pkg::COEF_BITS;
    localparam int GF    = dsbl_pkg::GAIN_FRAC;
    localparam int HF_W  = dsbl_pkg::HF_W;
    localparam int ENV_W = dsbl_pkg::ENV_W;
    localparam int AW    = dsbl_pkg::MAC_AW;
    localparam int BW    = dsbl_pkg::MAC_BW;
    localparam int ACC_W = dsbl_pkg::ACC_W;
    localparam int SUM_W = HF_W + 1;

    // settings
    logic [dsbl_pkg::THR_W-1:0] thr_reg;
    logic [C-1:0]               split_reg;
    logic [C-1:0]               gain_reg;
    logic [C-1:0]               attack_reg;
    logic [C-1:0]               release_reg;

    // sequencer and filter state
    dsbl_pkg::state_t   state_reg, state_next;
    logic signed [S-1:0]     mono_reg, mono_next;
    logic signed [S-1:0]     low_reg, low_next;
    logic signed [S:0]       mid_reg, mid_next;
    logic signed [S:0]       rest_reg, rest_next;
    logic signed [HF_W-1:0]  hf_reg, hf_next;
    logic [ENV_W-1:0]        env_reg, env_next;
    logic                    rise_reg, rise_next;
    logic                    neg_reg, neg_next;
    logic                    scale_reg, scale_next;
    logic [S-1:0]            out_reg, out_next;
    logic                    m_tvalid_reg, m_tvalid_next;

    // datapath helpers
    dsbl_pkg::mac_req_t          mac_req;
    logic signed [ACC_W-1:0]     acc;
    logic [C:0]                  fo;
    logic signed [S:0]           in_sum;
    logic signed [S-1:0]         low_new;
    logic signed [S:0]           mid_new;
    logic signed [S+1:0]         diff;
    logic signed [HF_W-1:0]      hf_new;
    logic signed [HF_W-1:0]      env_s;
    logic [ENV_W-1:0]            env_step;
    logic [ENV_W-1:0]            env_new;
    logic signed [ACC_W-1:0]     prod_mag;
    logic signed [HF_W-1:0]      hf_fin;
    logic signed [SUM_W-1:0]     sum;
    logic                        div_start;
    logic [dsbl_pkg::DIV_N-1:0]  quo;
    dsbl_pkg::div_stat_t         div_stat;

    dsbl_mac u_mac (
        .aclk (aclk),
        .req  (mac_req),
        .acc  (acc)
    );

    dsbl_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .dvd_mag (prod_mag[dsbl_pkg::DVD_W-1:0]),
        .dvs     (env_reg),
        .quo     (quo),
        .stat    (div_stat)
    );

    assign fo       = dsbl_pkg::COEF_ONE - {1'b0, split_reg};
    assign in_sum   = $signed({s_tdata[S-1], s_tdata[S-1:0]})
                    + $signed({s_tdata[2*S-1], s_tdata[2*S-1:S]});
    assign low_new  = acc[C+S-1:C];
    assign mid_new  = acc[C+S:C];
    assign diff     = $signed({rest_reg[S], rest_reg}) - $signed({mid_new[S], mid_new});
    assign hf_new   = acc[GF+HF_W-1:GF];
    assign env_s    = $signed({1'b0, env_reg});
    assign env_step = acc[C+ENV_W-1:C];
    assign env_new  = rise_reg ? env_reg + env_step : env_step;
    assign prod_mag = acc[ACC_W-1] ? -acc : acc;
    assign hf_fin   = !scale_reg ? hf_reg
                    : (neg_reg ? -$signed({1'b0, quo}) : $signed({1'b0, quo}));
    assign sum      = SUM_W'(low_reg) + SUM_W'(mid_reg) + SUM_W'(hf_fin);

    always_comb begin
        state_next    = state_reg;
        mono_next     = mono_reg;
        low_next      = low_reg;
        mid_next      = mid_reg;
        rest_next     = rest_reg;
        hf_next       = hf_reg;
        env_next      = env_reg;
        rise_next     = rise_reg;
        neg_next      = neg_reg;
        scale_next    = scale_reg;
        out_next      = out_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        mac_req.a     = '0;
        mac_req.b     = '0;
        mac_req.c     = '0;
        div_start     = 1'b0;
        s_tready      = 1'b0;

        case (state_reg)
            dsbl_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    mono_next  = in_sum[S:1];
                    state_next = dsbl_pkg::ST_LP1A;
                end
            end
            dsbl_pkg::ST_LP1A: begin
                mac_req.a  = AW'(low_reg);
                mac_req.b  = BW'(fo);
                mac_req.c  = ACC_W'(1) << (C - 1);
                state_next = dsbl_pkg::ST_LP1B;
            end
            dsbl_pkg::ST_LP1B: begin
                mac_req.a  = AW'(mono_reg);
                mac_req.b  = BW'(split_reg);
                mac_req.c  = acc;
                state_next = dsbl_pkg::ST_LP2A;
            end
            dsbl_pkg::ST_LP2A: begin
                low_next   = low_new;
                rest_next  = $signed({mono_reg[S-1], mono_reg})
                           - $signed({low_new[S-1], low_new});
                mac_req.a  = AW'(mid_reg);
                mac_req.b  = BW'(fo);
                mac_req.c  = ACC_W'(1) << (C - 1);
                state_next = dsbl_pkg::ST_LP2B;
            end
            dsbl_pkg::ST_LP2B: begin
                mac_req.a  = AW'(rest_reg);
                mac_req.b  = BW'(split_reg);
                mac_req.c  = acc;
                state_next = dsbl_pkg::ST_HF;
            end
            dsbl_pkg::ST_HF: begin
                mid_next   = mid_new;
                mac_req.a  = AW'(diff);
                mac_req.b  = BW'(gain_reg);
                mac_req.c  = ACC_W'(1) << (GF - 1);
                state_next = dsbl_pkg::ST_ENV;
            end
            dsbl_pkg::ST_ENV: begin
                hf_next = hf_new;
                // attack on rise, multiplicative release otherwise
                if (hf_new > env_s) begin
                    rise_next = 1'b1;
                    mac_req.a = AW'(hf_new) - AW'(env_s);
                    mac_req.b = BW'(attack_reg);
                end else begin
                    rise_next = 1'b0;
                    mac_req.a = AW'(env_s);
                    mac_req.b = BW'(release_reg);
                end
                state_next = dsbl_pkg::ST_ENV_UPD;
            end
            dsbl_pkg::ST_ENV_UPD: begin
                env_next   = env_new;
                mac_req.a  = AW'(hf_reg);
                mac_req.b  = BW'(thr_reg);
                scale_next = env_new > ENV_W'(thr_reg);
                state_next = (env_new > ENV_W'(thr_reg)) ? dsbl_pkg::ST_DIV_INIT
                                                         : dsbl_pkg::ST_SUM;
            end
            dsbl_pkg::ST_DIV_INIT: begin
                // divide magnitudes, then restore the sign: truncates toward zero
                neg_next   = acc[ACC_W-1];
                div_start  = 1'b1;
                state_next = dsbl_pkg::ST_DIV;
            end
            dsbl_pkg::ST_DIV: begin
                if (div_stat.done) begin
                    state_next = dsbl_pkg::ST_SUM;
                end
            end
            dsbl_pkg::ST_SUM: begin
                if (!m_tvalid_reg || m_tready) begin
                    if (sum[SUM_W-1:S-1] != {(SUM_W-S+1){sum[SUM_W-1]}}) begin
                        out_next = {sum[SUM_W-1], {(S-1){!sum[SUM_W-1]}}};
                    end else begin
                        out_next = sum[S-1:0];
                    end
                    m_tvalid_next = 1'b1;
                    state_next    = dsbl_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = dsbl_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= dsbl_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
            low_reg      <= '0;
            mid_reg      <= '0;
            env_reg      <= '0;
            thr_reg      <= dsbl_pkg::THRESHOLD_RST;
            split_reg    <= dsbl_pkg::SPLIT_RST;
            gain_reg     <= dsbl_pkg::GAIN_RST;
            attack_reg   <= dsbl_pkg::ATTACK_RST;
            release_reg  <= dsbl_pkg::RELEASE_RST;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            low_reg      <= low_next;
            mid_reg      <= mid_next;
            env_reg      <= env_next;
            if (cfg_we) begin
                case (cfg_index)
                    dsbl_pkg::CFG_THRESHOLD: thr_reg     <= cfg_wdata[dsbl_pkg::THR_W-1:0];
                    dsbl_pkg::CFG_SPLIT:     split_reg   <= cfg_wdata[C-1:0];
                    dsbl_pkg::CFG_GAIN:      gain_reg    <= cfg_wdata[C-1:0];
                    dsbl_pkg::CFG_ATTACK:    attack_reg  <= cfg_wdata[C-1:0];
                    dsbl_pkg::CFG_RELEASE:   release_reg <= cfg_wdata[C-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        mono_reg  <= mono_next;
        rest_reg  <= rest_next;
        hf_reg    <= hf_next;
        rise_reg  <= rise_next;
        neg_reg   <= neg_next;
        scale_reg <= scale_next;
        out_reg   <= out_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_reg;

    // an accepted word always starts the first filter step
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> state_reg == dsbl_pkg::ST_LP1A)
        else $error("accepted word did not start the sequence");

    // the divider only runs with a divisor above the threshold, never zero
    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == dsbl_pkg::ST_DIV_INIT |-> env_reg > ENV_W'(thr_reg))
        else $error("divider started without envelope above threshold");

    // a new result appears only out of the final step
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready |=> !m_tvalid || $past(state_reg == dsbl_pkg::ST_SUM))
        else $error("result word appeared outside the final step");

    // a finished result is held while the output register is still full
    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == dsbl_pkg::ST_SUM && m_tvalid && !m_tready
        |=> state_reg == dsbl_pkg::ST_SUM)
        else $error("result dropped while output stalled");

endmodule

`default_nettype wire

[hdl/dsbl_mac.sv]
// ----------------------------------------------------------------------------
// dsbl_mac
// Shared multiply-add: acc = a * b + c, registered, one result per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dsbl_mac (
    input  wire logic                            aclk,
    input  wire dsbl_pkg::mac_req_t              req,
    output logic signed [dsbl_pkg::ACC_W-1:0]    acc
);

    logic signed [dsbl_pkg::MAC_AW+dsbl_pkg::MAC_BW:0] prod;
    logic signed [dsbl_pkg::ACC_W-1:0]                 acc_reg;
    logic signed [dsbl_pkg::ACC_W-1:0]                 acc_next;

    // b is an unsigned weight, so it gets a zero sign bit
    assign prod     = req.a * $signed({1'b0, req.b});
    assign acc_next = dsbl_pkg::ACC_W'(prod) + req.c;

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire

[hdl/dsbl_div.sv]
// ----------------------------------------------------------------------------
// dsbl_div
// Restoring divider for the limiter gain, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dsbl_div (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [dsbl_pkg::DVD_W-1:0]    dvd_mag,
    input  wire logic [dsbl_pkg::DIV_N-1:0]    dvs,
    output logic      [dsbl_pkg::DIV_N-1:0]    quo,
    output dsbl_pkg::div_stat_t                stat
);

    localparam int N = dsbl_pkg::DIV_N;

    logic [N-1:0]               rem_reg, rem_next;
    logic [N-1:0]               q_reg, q_next;
    logic [dsbl_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [N:0]                 trial;
    logic [N:0]                 diff;
    logic                       ge;

    assign trial = {rem_reg, q_reg[N-1]};
    assign diff  = trial - {1'b0, dvs};
    assign ge    = trial >= {1'b0, dvs};

    always_comb begin
        rem_next  = rem_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            // upper part is below the divisor since the quotient fits n bits
            rem_next  = N'(dvd_mag[dsbl_pkg::DVD_W-1:N]);
            q_next    = dvd_mag[N-1:0];
            cnt_next  = dsbl_pkg::CNT_W'(N);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = ge ? diff[N-1:0] : trial[N-1:0];
            q_next   = {q_reg[N-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == dsbl_pkg::CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    assign quo       = q_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the split band de-esser. A scoreboard tracks both
// lowpass states, the envelope and the settings, and works out the mono word
// for every stereo word accepted. Each returned word is checked against it.
// Stimulus is a directed opening, then random phases under changing settings
// and changing idle patterns on both streams.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dsbl_pkg::*;

    localparam int     RANDOM_PER_PHASE = 236;
    localparam int     RANDOM_PHASES    = 8;
    localparam int     CYCLE_LIMIT      = 600000;
    localparam int     MAX_REPORTS      = 10;
    localparam int     TAIL_CYCLES      = 60;
    localparam int     FIRST_UNUSED_IDX = int'(CFG_RELEASE) + 1;
    localparam int     LAST_IDX         = (1 << CFG_IDX_W) - 1;

    localparam logic [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
    localparam logic [SAMPLE_BITS-1:0] S_ONE = SAMPLE_BITS'(1);

    localparam longint I32_MAX = 64'sd2147483647;
    localparam longint I32_MIN = -I32_MAX - 1;
    localparam longint OUT_MAX = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
    localparam longint OUT_MIN = -OUT_MAX - 1;

    class sibilance_scoreboard;
        longint thr;
        longint split_w;
        longint gain;
        longint attack;
        longint rel_coef;
        longint low_band;
        longint mid_band;
        longint env_level;
        logic [SAMPLE_BITS-1:0] pending_mono[$];
        int mismatches;
        int checked;

        function new();
            thr = THRESHOLD_RST;
            split_w = SPLIT_RST;
            gain = GAIN_RST;
            attack = ATTACK_RST;
            rel_coef = RELEASE_RST;
            low_band = 0;
            mid_band = 0;
            env_level = 0;
            mismatches = 0;
            checked = 0;
        endfunction

        // bits above a register's width are dropped, unused indexes change nothing
        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
            case (idx)
                CFG_THRESHOLD: thr = value[THR_W-1:0];
                CFG_SPLIT:     split_w = value[COEF_BITS-1:0];
                CFG_GAIN:      gain = value[COEF_BITS-1:0];
                CFG_ATTACK:    attack = value[COEF_BITS-1:0];
                CFG_RELEASE:   rel_coef = value[COEF_BITS-1:0];
                default: ;
            endcase
        endfunction

        function longint sat(longint x, longint lo, longint hi);
            if (x < lo)
                return lo;
            if (x > hi)
                return hi;
            return x;
        endfunction

        function longint one_pole(longint y, longint x);
            longint acc;
            acc = ((longint'(1) << COEF_BITS) - split_w) * y + split_w * x
                  + (longint'(1) << (COEF_BITS - 1));
            return sat(acc >>> COEF_BITS, I32_MIN, I32_MAX);
        endfunction

        function void take_sample(logic [SAMPLE_BITS-1:0] left, logic [SAMPLE_BITS-1:0] right);
            longint mono;
            longint rest;
            longint hf;
            longint sum;
            mono = (longint'($signed(left)) + longint'($signed(right))) >>> 1;
            low_band = one_pole(low_band, mono);
            rest = mono - low_band;
            mid_band = one_pole(mid_band, rest);
            hf = (gain * (rest - mid_band) + (longint'(1) << (GAIN_FRAC - 1))) >>> GAIN_FRAC;
            hf = sat(hf, I32_MIN, I32_MAX);
            if (hf > env_level)
                env_level = env_level + ((attack * (hf - env_level)) >>> COEF_BITS);
            else
                env_level = (env_level * rel_coef) >>> COEF_BITS;
            env_level = sat(env_level, 0, I32_MAX);
            // gain reduction, quotient truncated toward zero
            if (env_level > thr)
                hf = (hf * thr) / env_level;
            sum = sat(low_band + mid_band + hf, OUT_MIN, OUT_MAX);
            pending_mono.push_back(sum[SAMPLE_BITS-1:0]);
        endfunction

        function void check_mono(logic [SAMPLE_BITS-1:0] got);
            logic [SAMPLE_BITS-1:0] want;
            if (pending_mono.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected mono word %0d", $signed(got));
                return;
            end
            want = pending_mono.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("word %0d mono_out: expected %0d, got %0d",
                             checked, $signed(want), $signed(got));
            end
            checked++;
        endfunction
    endclass

    logic                         aclk = 1'b0;
    logic                         aresetn;
    logic                         cfg_we;
    logic [CFG_IDX_W-1:0]         cfg_index;
    logic [CFG_W-1:0]             cfg_wdata;
    logic                         s_tvalid;
    logic                         s_tready;
    logic [2*SAMPLE_BITS-1:0]     s_tdata;     // left_in, right_in
    logic                         m_tvalid;
    logic                         m_tready;
    logic [SAMPLE_BITS-1:0]       m_tdata;     // mono_out

    sibilance_scoreboard sb = new();

    int tx_idle_pct = 24;
    int rx_idle_pct = 47;
    bit hold_request = 1'b0;
    bit tone_sign = 1'b0;
    int cycle_count = 0;

    deesser_split_band_limiter dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_mono(m_tdata);
    end

    // receiver: random stalls, or a long hold-off when asked
    initial begin
        int hold_cycles;
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_cycles = $urandom_range(200, 400);
                m_tready <= 1'b0;
                repeat (hold_cycles) @(posedge aclk);
                hold_request = 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        sb.set_reg(idx, value);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_word(logic [SAMPLE_BITS-1:0] left, logic [SAMPLE_BITS-1:0] right);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {right, left};
        do
            @(posedge aclk);
        while (!s_tready);
        sb.take_sample(left, right);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending_mono.size() != 0)
            @(posedge aclk);
        @(posedge aclk);
    endtask

    task automatic random_settings();
        logic [CFG_W-1:0] thr_value;
        case ($urandom_range(0, 3))
            0: thr_value = CFG_W'($urandom_range(0, (1 << THR_W) - 1));
            1: thr_value = CFG_W'($urandom_range(0, 200000));
            2: thr_value = '0;
            default: thr_value = '1;
        endcase
        write_reg(CFG_THRESHOLD, thr_value);
        write_reg(CFG_SPLIT, CFG_W'($urandom));
        write_reg(CFG_GAIN, CFG_W'($urandom));
        write_reg(CFG_ATTACK, CFG_W'($urandom));
        // release mostly close to one so the envelope holds on
        if ($urandom_range(0, 3) != 0)
            write_reg(CFG_RELEASE, {(CFG_W - COEF_BITS)'($urandom),
                                    COEF_BITS'($urandom_range(60000, 65535))});
        else
            write_reg(CFG_RELEASE, CFG_W'($urandom));
        write_reg(CFG_IDX_W'($urandom_range(FIRST_UNUSED_IDX, LAST_IDX)), CFG_W'($urandom));
    endtask

    task automatic random_words(int count);
        logic [SAMPLE_BITS-1:0] left;
        logic [SAMPLE_BITS-1:0] right;
        logic [SAMPLE_BITS-1:0] amp;
        repeat (count) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    left = SAMPLE_BITS'($urandom);
                    right = SAMPLE_BITS'($urandom);
                end
                4, 5: begin
                    left = SAMPLE_BITS'($urandom);
                    right = left + SAMPLE_BITS'(int'($urandom_range(0, 4096)) - 2048);
                end
                6, 7: begin
                    // high frequency swing, drives the envelope past the threshold
                    amp = SAMPLE_BITS'($urandom_range(1 << 20, (1 << (SAMPLE_BITS - 1)) - 1));
                    tone_sign = ~tone_sign;
                    left = tone_sign ? amp : -amp;
                    right = left ^ SAMPLE_BITS'($urandom_range(0, 255));
                end
                8: begin
                    left = SAMPLE_BITS'(int'($urandom_range(0, 512)) - 256);
                    right = SAMPLE_BITS'(int'($urandom_range(0, 512)) - 256);
                end
                default: begin
                    case ($urandom_range(0, 3))
                        0: left = S_MAX;
                        1: left = S_MIN;
                        2: left = '0;
                        default: left = '1;
                    endcase
                    right = $urandom_range(0, 1) ? S_MAX : S_MIN;
                end
            endcase
            send_word(left, right);
        end
    endtask

    initial begin
        int phase;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // defaults: extremes, odd negative sum, full scale swings over the low threshold
        send_word('0, '0);
        send_word(S_MAX, S_MAX);
        send_word(S_MIN, S_MIN);
        send_word(S_MAX, S_MIN);
        send_word('1, '0);
        send_word(S_MAX, S_MAX);
        send_word(S_MIN, S_MIN);
        send_word(S_MAX, S_MAX);
        send_word(S_MIN, S_MIN);
        send_word(S_ONE, '1);
        drain();

        // zero threshold and frozen lowpass states, coefficient written with junk above
        write_reg(CFG_THRESHOLD, '0);
        write_reg(CFG_SPLIT, {{(CFG_W - COEF_BITS){1'b1}}, {COEF_BITS{1'b0}}});
        write_reg(CFG_IDX_W'($urandom_range(FIRST_UNUSED_IDX, LAST_IDX)), CFG_W'($urandom));
        send_word(S_MAX, S_MAX);
        send_word(S_MIN, S_MIN);
        send_word(S_MAX, S_MIN);
        send_word(SAMPLE_BITS'(12345), SAMPLE_BITS'(-54321));
        send_word(S_MIN, S_MAX);
        send_word('0, '0);
        drain();

        // every register at its top value
        write_reg(CFG_THRESHOLD, '1);
        write_reg(CFG_SPLIT, '1);
        write_reg(CFG_GAIN, '1);
        write_reg(CFG_ATTACK, '1);
        write_reg(CFG_RELEASE, '1);
        send_word(S_MAX, S_MAX);
        send_word(S_MIN, S_MIN);
        send_word(S_MAX, S_MAX);
        send_word(S_MIN, S_MIN);
        send_word(S_MIN, S_MAX);
        send_word(S_MAX, S_MAX);
        drain();

        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            if (phase == 3) begin
                tx_idle_pct = 47;
                rx_idle_pct = 24;
            end
            if (phase == 6) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (phase == 0) begin
                write_reg(CFG_THRESHOLD, '0);
                write_reg(CFG_SPLIT, '0);
                write_reg(CFG_GAIN, '0);
                write_reg(CFG_ATTACK, '0);
                write_reg(CFG_RELEASE, '0);
            end else begin
                random_settings();
            end
            // long output stall while words keep coming
            if (phase == 2 || phase == 6)
                hold_request = 1'b1;
            random_words(RANDOM_PER_PHASE / 2);
            if (phase == 4)
                drain();
            random_words(RANDOM_PER_PHASE - RANDOM_PER_PHASE / 2);
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending_mono.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
